// ===== src/psvd_pkg.sv =====
// shared types, constants and conversion functions of the plot stream decoder
// no dependencies
package psvd_pkg;

    localparam int COORD_BITS = 48;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_BITS  = COORD_BITS + 13;
    localparam int Q_BITS     = 22;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    // argument kinds of the command table
    localparam logic [3:0] K_BAD   = 4'd0;
    localparam logic [3:0] K_NONE  = 4'd1;
    localparam logic [3:0] K_SHORT = 4'd2;
    localparam logic [3:0] K_IEEE  = 4'd3;
    localparam logic [3:0] K_CHAR  = 4'd4;
    localparam logic [3:0] K_TEXT  = 4'd5;

    // command letters
    localparam logic [7:0] CH_NL  = 8'h0A;
    localparam logic [7:0] CH_A   = 8'h41;
    localparam logic [7:0] CH_LZ  = 8'h7A;
    localparam logic [7:0] CH_F   = 8'h46;
    localparam logic [7:0] CH_LS  = 8'h73;
    localparam logic [7:0] CH_LW  = 8'h77;
    localparam logic [7:0] CH_US  = 8'h53;
    localparam logic [7:0] CH_UW  = 8'h57;
    localparam logic [7:0] CH_LM  = 8'h6D;
    localparam logic [7:0] CH_LO  = 8'h6F;
    localparam logic [7:0] CH_UM  = 8'h4D;
    localparam logic [7:0] CH_UO  = 8'h4F;
    localparam logic [7:0] CH_LN  = 8'h6E;
    localparam logic [7:0] CH_LQ  = 8'h71;
    localparam logic [7:0] CH_UN  = 8'h4E;
    localparam logic [7:0] CH_UQ  = 8'h51;
    localparam logic [7:0] CH_LL  = 8'h6C;
    localparam logic [7:0] CH_LV  = 8'h76;
    localparam logic [7:0] CH_UL  = 8'h4C;
    localparam logic [7:0] CH_UV  = 8'h56;
    localparam logic [7:0] CH_LP  = 8'h70;
    localparam logic [7:0] CH_LX  = 8'h78;
    localparam logic [7:0] CH_UP  = 8'h50;
    localparam logic [7:0] CH_UX  = 8'h58;

    // kind in the upper nibble, argument count in the lower, from 'A'
    localparam logic [7:0] CMD_TABLE [58] = '{
        8'h00, 8'h00, 8'h43, 8'h00, 8'h00, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h26, 8'h23, 8'h23, 8'h33, 8'h23, 8'h33, 8'h00, 8'h26, 8'h00,
        8'h00, 8'h36, 8'h36, 8'h33, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h26, 8'h00, 8'h23, 8'h00, 8'h10, 8'h51, 8'h00, 8'h00, 8'h33, 8'h00,
        8'h00, 8'h24, 8'h22, 8'h22, 8'h32, 8'h22, 8'h32, 8'h36, 8'h24, 8'h51,
        8'h00, 8'h34, 8'h34, 8'h32, 8'h00, 8'h00
    };

    typedef enum logic [2:0] {
        EV_LINE  = 3'd0,
        EV_ERASE = 3'd1,
        EV_FLUSH = 3'd2,
        EV_BAD   = 3'd3,
        EV_DEGEN = 3'd4
    } t_event;

    typedef enum logic [1:0] {
        PH_CMD  = 2'd0,
        PH_ARGS = 2'd1,
        PH_TEXT = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        J_EVENT = 2'd0,
        J_SPACE = 2'd1,
        J_MOVE  = 2'd2,
        J_DRAW  = 2'd3
    } t_job_op;

    typedef enum logic [2:0] {
        B_IDLE = 3'd0,
        B_SUB  = 3'd1,
        B_MUL  = 3'd2,
        B_DIV  = 3'd3,
        B_FIX  = 3'd4,
        B_DONE = 3'd5
    } t_bstate;

    // one decoded command handed from the parser to the executor
    typedef struct packed {
        t_job_op op;
        t_event  evt;
        logic [7:0] bad;
        logic    use_cur;
        t_coord  v0;
        t_coord  v1;
        t_coord  v2;
        t_coord  v3;
    } t_job;

    function automatic logic [7:0] cmd_entry(input logic [7:0] b);
        logic [7:0] off;
        off = b - CH_A;
        if (b >= CH_A && b <= CH_LZ) begin
            return CMD_TABLE[off[5:0]];
        end
        return 8'h00;
    endfunction

    function automatic t_coord make_fixed(input logic neg, input logic [63:0] mag);
        logic [63:0] maxpos;
        logic [63:0] m;
        maxpos = (64'd1 << (COORD_BITS - 1)) - 64'd1;
        if (!neg) begin
            return (mag > maxpos) ? maxpos[COORD_BITS-1:0] : mag[COORD_BITS-1:0];
        end
        m = (mag > maxpos + 64'd1) ? maxpos + 64'd1 : mag;
        return t_coord'(-(m[COORD_BITS-1:0]));
    endfunction

    function automatic t_coord short_to_fixed(input logic [15:0] raw);
        logic signed [63:0] w;
        w = 64'(signed'(raw)) <<< FRAC_BITS;
        return w[COORD_BITS-1:0];
    endfunction

    function automatic t_coord ieee_to_fixed(input logic [63:0] bits);
        logic        neg;
        logic [10:0] expo;
        logic [63:0] mant;
        logic signed [12:0] sh;
        logic [12:0] nsh;
        logic [63:0] mag;
        neg  = bits[63];
        expo = bits[62:52];
        mant = {12'd0, bits[51:0]};
        if (expo == 11'h7FF) begin
            if (mant != 64'd0) begin
                return '0;
            end
            return make_fixed(neg, '1);
        end
        if (expo == 11'd0) begin
            sh = 13'(-1074 + FRAC_BITS);
        end else begin
            mant[52] = 1'b1;
            sh = signed'({2'b00, expo}) - 13'(1075 - FRAC_BITS);
        end
        if (mant == 64'd0) begin
            return '0;
        end
        if (sh > 13'sd10) begin
            return make_fixed(neg, '1);
        end
        nsh = 13'(-sh);
        if (sh >= 13'sd0) begin
            mag = mant << sh[3:0];
        end else if (sh <= -13'sd64) begin
            mag = 64'd0;
        end else begin
            mag = mant >> nsh[5:0];
        end
        return make_fixed(neg, mag);
    endfunction

endpackage

// ===== src/psvd_front.sv =====
// command parser: assembles arguments and turns finished commands into jobs
// depends on psvd_pkg
module psvd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_take,
    input  logic [7:0]      i_byte,
    output logic            o_push,
    output psvd_pkg::t_job  o_job
);
    import psvd_pkg::*;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_cmd, n_cmd;
    logic [2:0]  r_aidx, n_aidx;
    logic [2:0]  r_bidx, n_bidx;
    logic [63:0] r_asm, n_asm;
    t_coord      r_arg [6];
    t_coord      n_arg [6];

    logic [7:0]  entry;
    logic [3:0]  kind;
    logic [2:0]  aidx_inc;
    logic        done;

    always_comb begin
        n_phase  = r_phase;
        n_cmd    = r_cmd;
        n_aidx   = r_aidx;
        n_bidx   = r_bidx;
        n_asm    = r_asm;
        n_arg    = r_arg;
        o_push   = 1'b0;
        o_job    = '0;
        done     = 1'b0;
        entry    = 8'h00;
        kind     = K_BAD;
        aidx_inc = r_aidx + 3'd1;
        if (i_take) begin
            unique case (r_phase)
                PH_TEXT: begin
                    if (i_byte == CH_NL) begin
                        n_phase = PH_CMD;
                    end
                end
                PH_ARGS: begin
                    entry = cmd_entry(r_cmd);
                    kind  = entry[7:4];
                    if (kind == K_SHORT) begin
                        n_asm = r_asm | ({56'd0, i_byte} << {r_bidx[0], 3'b000});
                        if (r_bidx >= 3'd1) begin
                            n_arg[r_aidx] = short_to_fixed(n_asm[15:0]);
                            done = 1'b1;
                        end
                    end else if (kind == K_IEEE) begin
                        n_asm = {r_asm[55:0], i_byte};
                        if (r_bidx >= 3'd7) begin
                            n_arg[r_aidx] = ieee_to_fixed(n_asm);
                            done = 1'b1;
                        end
                    end else begin
                        done = 1'b1;
                    end
                    if (!done) begin
                        n_bidx = r_bidx + 3'd1;
                    end else begin
                        n_bidx = 3'd0;
                        n_asm  = '0;
                        n_aidx = aidx_inc;
                        if ({1'b0, aidx_inc} >= entry[3:0]) begin
                            n_phase = PH_CMD;
                            n_aidx  = 3'd0;
                            o_job.op = J_DRAW;
                            o_push   = 1'b1;
                            case (r_cmd)
                                CH_LS, CH_LW: begin
                                    o_job.op = J_SPACE;
                                    o_job.v0 = n_arg[0]; o_job.v1 = n_arg[1];
                                    o_job.v2 = n_arg[2]; o_job.v3 = n_arg[3];
                                end
                                CH_US, CH_UW: begin
                                    o_job.op = J_SPACE;
                                    o_job.v0 = n_arg[0]; o_job.v1 = n_arg[1];
                                    o_job.v2 = n_arg[3]; o_job.v3 = n_arg[4];
                                end
                                CH_LM, CH_LO, CH_UM, CH_UO: begin
                                    o_job.op = J_MOVE;
                                    o_job.v0 = n_arg[0]; o_job.v1 = n_arg[1];
                                end
                                CH_LN, CH_LQ, CH_UN, CH_UQ: begin
                                    o_job.use_cur = 1'b1;
                                    o_job.v2 = n_arg[0]; o_job.v3 = n_arg[1];
                                end
                                CH_LL, CH_LV: begin
                                    o_job.v0 = n_arg[0]; o_job.v1 = n_arg[1];
                                    o_job.v2 = n_arg[2]; o_job.v3 = n_arg[3];
                                end
                                CH_UL, CH_UV: begin
                                    o_job.v0 = n_arg[0]; o_job.v1 = n_arg[1];
                                    o_job.v2 = n_arg[3]; o_job.v3 = n_arg[4];
                                end
                                CH_LP, CH_LX, CH_UP, CH_UX: begin
                                    o_job.v0 = n_arg[0]; o_job.v1 = n_arg[1];
                                    o_job.v2 = n_arg[0]; o_job.v3 = n_arg[1];
                                end
                                default: begin
                                    o_push = 1'b0;
                                end
                            endcase
                        end
                    end
                end
                default: begin
                    entry = cmd_entry(i_byte);
                    kind  = entry[7:4];
                    n_phase = PH_CMD;
                    if (kind == K_BAD) begin
                        o_push    = 1'b1;
                        o_job.op  = J_EVENT;
                        o_job.evt = EV_BAD;
                        o_job.bad = i_byte;
                    end else if (kind == K_NONE) begin
                        o_push    = 1'b1;
                        o_job.op  = J_EVENT;
                        o_job.evt = (i_byte == CH_F) ? EV_FLUSH : EV_ERASE;
                    end else if (kind == K_TEXT) begin
                        n_phase = PH_TEXT;
                    end else begin
                        n_cmd   = i_byte;
                        n_aidx  = 3'd0;
                        n_bidx  = 3'd0;
                        n_asm   = '0;
                        n_phase = PH_ARGS;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_CMD;
            r_cmd   <= '0;
            r_aidx  <= '0;
            r_bidx  <= '0;
            r_asm   <= '0;
        end else begin
            r_phase <= n_phase;
            r_cmd   <= n_cmd;
            r_aidx  <= n_aidx;
            r_bidx  <= n_bidx;
            r_asm   <= n_asm;
        end
        r_arg <= n_arg;
    end

endmodule

// ===== src/psvd_jobq.sv =====
// two-entry job queue between parser and executor
// depends on psvd_pkg
module psvd_jobq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  psvd_pkg::t_job  i_job,
    input  logic            i_pop,
    output psvd_pkg::t_job  o_job,
    output logic            o_empty,
    output logic            o_full
);
    import psvd_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       do_push, do_pop;

    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_job   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

// ===== src/psvd_back.sv =====
// executor: keeps window and current point, maps segments with a serial divider
// depends on psvd_pkg
module psvd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  psvd_pkg::t_job  i_job,
    input  logic            i_job_empty,
    output logic            o_job_pop,
    input  logic [12:0]     i_width,
    input  logic [12:0]     i_height,
    input  logic            i_out_pop,
    output logic            o_out_valid,
    output logic [2:0]      o_kind,
    output logic [15:0]     o_sx,
    output logic [15:0]     o_sy,
    output logic [15:0]     o_ex,
    output logic [15:0]     o_ey,
    output logic [7:0]      o_bad
);
    import psvd_pkg::*;

    t_bstate r_state, n_state;

    t_coord r_win [4];
    t_coord r_cp  [2];
    t_coord r_pt  [4];
    logic [15:0] r_res [4];
    logic [1:0]  r_c;
    logic        r_ok;
    logic        r_neg;
    logic [COORD_BITS-1:0] r_nmag, r_dmag;
    logic [PROD_BITS-1:0]  r_prod;
    logic [COORD_BITS-1:0] r_rem;
    logic [Q_BITS-1:0]     r_q;
    logic [5:0]  r_cnt;

    logic        r_ov;
    logic [2:0]  r_kind;
    logic [15:0] r_sx, r_sy, r_ex, r_ey;
    logic [7:0]  r_bad;

    // coordinate selection for the current step
    t_coord      v_sel, lo_sel, hi_sel;
    logic [12:0] scale;
    logic        nneg, dneg;
    logic [COORD_BITS-1:0] nmag, dmag;

    // divider step
    logic [COORD_BITS:0]   r2;
    logic                  ge;
    logic [Q_BITS-1:0]     q2;

    // final fix-up
    logic signed [23:0] qs, ss, t, tfix;
    logic [15:0] sat;

    logic start;

    assign v_sel  = r_pt[r_c];
    assign lo_sel = r_win[{1'b0, r_c[0]}];
    assign hi_sel = r_win[{1'b1, r_c[0]}];
    assign scale  = r_c[0] ? i_height : i_width;
    assign nneg   = v_sel < lo_sel;
    assign dneg   = hi_sel < lo_sel;
    assign nmag   = nneg ? lo_sel - v_sel : v_sel - lo_sel;
    assign dmag   = dneg ? lo_sel - hi_sel : hi_sel - lo_sel;

    assign r2 = {r_rem, r_prod[r_cnt]};
    assign ge = r2 >= {1'b0, r_dmag};

    always_comb begin
        q2 = {r_q[Q_BITS-2:0], ge};
        if (q2 > Q_BITS'(1 << 20)) begin
            q2 = Q_BITS'(1 << 20);
        end
    end

    always_comb begin
        qs = {2'b00, r_q};
        ss = {11'd0, scale};
        tfix = '0;
        if (!r_c[0]) begin
            t = r_neg ? -qs : qs;
        end else if (r_neg) begin
            t = ss + qs;
        end else if (r_rem == '0) begin
            t = ss - qs;
        end else begin
            tfix = ss - qs - 24'sd1;
            t = (tfix < 0) ? ss - qs : tfix;
        end
        if (t > 24'sd32767) begin
            sat = 16'h7FFF;
        end else if (t < -24'sd32768) begin
            sat = 16'h8000;
        end else begin
            sat = t[15:0];
        end
    end

    assign start = (r_state == B_IDLE) && !i_job_empty && !r_ov;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: if (start && i_job.op == J_DRAW) n_state = B_SUB;
            B_SUB: begin
                if (dmag == '0) begin
                    n_state = (r_c == 2'd3) ? B_DONE : B_SUB;
                end else begin
                    n_state = B_MUL;
                end
            end
            B_MUL:  n_state = B_DIV;
            B_DIV:  if (r_cnt == 6'd0) n_state = B_FIX;
            B_FIX:  n_state = (r_c == 2'd3) ? B_DONE : B_SUB;
            B_DONE: n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_job_pop = start;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_ov    <= 1'b0;
            r_win   <= '{default: '0};
            r_cp    <= '{default: '0};
        end else begin
            r_state <= n_state;
            if (r_ov && i_out_pop) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (start) begin
                        case (i_job.op)
                            J_EVENT: r_ov <= 1'b1;
                            J_SPACE: begin
                                r_win[0] <= i_job.v0; r_win[1] <= i_job.v1;
                                r_win[2] <= i_job.v2; r_win[3] <= i_job.v3;
                            end
                            J_MOVE: begin
                                r_cp[0] <= i_job.v0; r_cp[1] <= i_job.v1;
                            end
                            default: ;
                        endcase
                    end
                end
                B_DONE: begin
                    r_cp[0] <= r_pt[2];
                    r_cp[1] <= r_pt[3];
                    r_ov    <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // datapath; outputs load only at job start or segment end, so a result holds
    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                if (start) begin
                    r_kind <= i_job.evt;
                    r_bad  <= i_job.bad;
                    r_sx <= '0; r_sy <= '0; r_ex <= '0; r_ey <= '0;
                    r_c  <= 2'd0;
                    r_ok <= 1'b1;
                    r_pt[0] <= i_job.use_cur ? r_cp[0] : i_job.v0;
                    r_pt[1] <= i_job.use_cur ? r_cp[1] : i_job.v1;
                    r_pt[2] <= i_job.v2;
                    r_pt[3] <= i_job.v3;
                end
            end
            B_SUB: begin
                r_nmag <= nmag;
                r_dmag <= dmag;
                r_neg  <= nneg ^ dneg;
                if (dmag == '0) begin
                    r_ok <= 1'b0;
                    r_c  <= r_c + 2'd1;
                end
            end
            B_MUL: begin
                r_prod <= PROD_BITS'(r_nmag * scale);
                r_rem  <= '0;
                r_q    <= '0;
                r_cnt  <= 6'(PROD_BITS - 1);
            end
            B_DIV: begin
                r_rem <= ge ? COORD_BITS'(r2 - {1'b0, r_dmag}) : r2[COORD_BITS-1:0];
                r_q   <= q2;
                r_cnt <= r_cnt - 6'd1;
            end
            B_FIX: begin
                r_res[r_c] <= sat;
                r_c <= r_c + 2'd1;
            end
            B_DONE: begin
                r_kind <= r_ok ? EV_LINE : EV_DEGEN;
                r_bad  <= '0;
                if (r_ok) begin
                    r_sx <= r_res[0]; r_sy <= r_res[1];
                    r_ex <= r_res[2]; r_ey <= r_res[3];
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_ov;
    assign o_kind = r_kind;
    assign o_sx   = r_sx;
    assign o_sy   = r_sy;
    assign o_ex   = r_ex;
    assign o_ey   = r_ey;
    assign o_bad  = r_bad;

endmodule

// ===== src/plot_stream_vector_decoder.sv =====
// plot stream decoder top level: config registers, parser, job queue, executor
// depends on psvd_pkg, psvd_front, psvd_jobq, psvd_back
// the last byte of a command registers its job in the queue; the executor sets
//   an event result on taking the job, a segment once the divider has mapped it
// throughput: 1 byte per cycle while the two-entry job queue has room;
//   the executor takes a new job only once the previous result is popped
// reset: synchronous active-low; window cleared, current point at origin,
//   window width and height back to 512
module plot_stream_vector_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte stream in
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_stream_byte,
    // event stream out
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_event_kind,
    output logic signed [15:0] o_start_x,
    output logic signed [15:0] o_start_y,
    output logic signed [15:0] o_end_x,
    output logic signed [15:0] o_end_y,
    output logic [7:0]  o_bad_byte,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import psvd_pkg::*;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    logic [12:0] r_width, r_height;
    logic        take;
    logic        job_push, job_pop, jq_empty, jq_full;
    t_job        job_in, job_out;
    logic        out_valid;

    // config registers, always ready, select by the word address bit
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 13'd512;
            r_height <= 13'd512;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_WIDTH) begin
                r_width <= pwdata[12:0];
            end else begin
                r_height <= pwdata[12:0];
            end
        end
    end
    assign prdata = {19'd0, (paddr[2] == REG_HEIGHT) ? r_height : r_width};

    // input transfer when queue has room for whatever the byte produces
    assign full = jq_full;
    assign take = push && !full;

    psvd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (i_stream_byte),
        .o_push  (job_push),
        .o_job   (job_in)
    );

    psvd_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .i_pop   (job_pop),
        .o_job   (job_out),
        .o_empty (jq_empty),
        .o_full  (jq_full)
    );

    psvd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job_out),
        .i_job_empty (jq_empty),
        .o_job_pop   (job_pop),
        .i_width     (r_width),
        .i_height    (r_height),
        .i_out_pop   (pop),
        .o_out_valid (out_valid),
        .o_kind      (o_event_kind),
        .o_sx        (o_start_x),
        .o_sy        (o_start_y),
        .o_ex        (o_end_x),
        .o_ey        (o_end_y),
        .o_bad       (o_bad_byte)
    );

    // result transfer when pop and a result is waiting
    assign empty = !out_valid;

    // a job is never pushed into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(job_push && jq_full))
        else $error("job pushed into full queue");

    // executor only pops a waiting job
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(job_pop && jq_empty))
        else $error("job popped from empty queue");

    // only line segments carry coordinates
    a_coords_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_event_kind != EV_LINE) |->
            (o_start_x == 16'sd0 && o_start_y == 16'sd0 &&
             o_end_x == 16'sd0 && o_end_y == 16'sd0))
        else $error("coordinates on a non-segment event");

    // a waiting result stays put until popped
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_event_kind) && $stable(o_end_x)))
        else $error("waiting result changed");

endmodule

// ===== sim/plot_stream_vector_decoder_test.sv =====
`timescale 1ns / 100ps
// self-checking bench for plot_stream_vector_decoder: random plot byte streams,
// exact event prediction, queue handshakes and register writes; depends on psvd_pkg
module plot_stream_vector_decoder_test;
    import psvd_pkg::*;

    typedef struct {
        t_event             kind;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [15:0] ex;
        logic signed [15:0] ey;
        logic [7:0]         bad;
    } t_plot_event;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic [7:0]         i_stream_byte = 8'd0;
    logic               empty;
    logic               pop = 1'b0;
    logic [2:0]         o_event_kind;
    logic signed [15:0] o_start_x, o_start_y, o_end_x, o_end_y;
    logic [7:0]         o_bad_byte;
    logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]         paddr = 3'd0;
    logic [31:0]        pwdata = 32'd0;
    logic [31:0]        prdata;
    logic               pready;

    plot_stream_vector_decoder dut (.*);

    always #4 i_clk = ~i_clk;

    // stimulus bytes not yet transferred and events still owed by the block
    logic [7:0]  stream_bytes [$];
    t_plot_event events_due [$];
    int          mismatches = 0;

    // decoder state mirrored by the bench
    t_phase      dec_phase = PH_CMD;
    logic [7:0]  dec_cmd = 8'd0;
    int          dec_arg = 0;
    int          dec_byte = 0;
    logic [63:0] dec_asm = 64'd0;
    longint      dec_args [6];
    longint      win [4];
    longint      pen [2];
    logic [12:0] win_w = 13'd512;
    logic [12:0] win_h = 13'd512;

    function automatic longint fixed_of(input bit neg, input logic [63:0] mag);
        logic [63:0] maxpos;
        maxpos = (64'd1 << (COORD_BITS - 1)) - 64'd1;
        if (!neg) begin
            return (mag > maxpos) ? longint'(maxpos) : longint'(mag);
        end
        if (mag > maxpos + 64'd1) begin
            mag = maxpos + 64'd1;
        end
        return -longint'(mag);
    endfunction

    function automatic longint fixed_of_double(input logic [63:0] bits);
        int          sh;
        logic [63:0] mant;
        mant = {12'd0, bits[51:0]};
        if (bits[62:52] == 11'h7FF) begin
            return (mant != 0) ? 64'sd0 : fixed_of(bits[63], '1);
        end
        if (bits[62:52] == 11'd0) begin
            sh = -1074 + FRAC_BITS;
        end else begin
            mant[52] = 1'b1;
            sh = int'(bits[62:52]) - 1075 + FRAC_BITS;
        end
        if (mant == 0) begin
            return 0;
        end
        if (sh > 10) begin
            return fixed_of(bits[63], '1);
        end
        if (sh >= 0) begin
            return fixed_of(bits[63], mant << sh);
        end
        if (sh <= -64) begin
            return 0;
        end
        return fixed_of(bits[63], mant >> (-sh));
    endfunction

    function automatic logic signed [15:0] clip16(input longint v);
        if (v > 32767) begin
            return 16'sh7FFF;
        end
        if (v < -32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    // one axis of the window mapping; returns 0 when the window extent is zero
    function automatic bit map_axis(input longint v, input longint lo, input longint hi,
                                    input logic [12:0] scale, input bit flip,
                                    output logic signed [15:0] pix);
        bit          nneg, dneg;
        logic [63:0] nmag, dmag, prod, quo, rem;
        longint      t;
        nneg = v < lo;
        dneg = hi < lo;
        nmag = nneg ? lo - v : v - lo;
        dmag = dneg ? lo - hi : hi - lo;
        pix = 16'sd0;
        if (dmag == 0) begin
            return 1'b0;
        end
        prod = nmag * {51'd0, scale};
        quo = prod / dmag;
        rem = prod % dmag;
        if (quo > 64'd1048576) begin
            quo = 64'd1048576;
        end
        if (!flip) begin
            pix = clip16((nneg != dneg) ? -longint'(quo) : longint'(quo));
            return 1'b1;
        end
        if (nneg != dneg) begin
            t = longint'(scale) + longint'(quo);
        end else if (rem == 0) begin
            t = longint'(scale) - longint'(quo);
        end else begin
            t = longint'(scale) - longint'(quo) - 1;
            if (t < 0) begin
                t = longint'(scale) - longint'(quo);
            end
        end
        pix = clip16(t);
        return 1'b1;
    endfunction

    task automatic predict_segment(input longint ax, input longint ay,
                                   input longint bx, input longint by);
        t_plot_event e;
        bit          ok;
        e = '{EV_LINE, 0, 0, 0, 0, 8'd0};
        ok = map_axis(ax, win[0], win[2], win_w, 1'b0, e.sx);
        ok = map_axis(ay, win[1], win[3], win_h, 1'b1, e.sy) && ok;
        ok = map_axis(bx, win[0], win[2], win_w, 1'b0, e.ex) && ok;
        ok = map_axis(by, win[1], win[3], win_h, 1'b1, e.ey) && ok;
        pen[0] = bx;
        pen[1] = by;
        if (!ok) begin
            e = '{EV_DEGEN, 0, 0, 0, 0, 8'd0};
        end
        events_due.push_back(e);
    endtask

    task automatic run_command();
        case (dec_cmd)
            CH_LS, CH_LW: begin
                win[0] = dec_args[0]; win[1] = dec_args[1];
                win[2] = dec_args[2]; win[3] = dec_args[3];
            end
            CH_US, CH_UW: begin
                win[0] = dec_args[0]; win[1] = dec_args[1];
                win[2] = dec_args[3]; win[3] = dec_args[4];
            end
            CH_LM, CH_LO, CH_UM, CH_UO: begin
                pen[0] = dec_args[0];
                pen[1] = dec_args[1];
            end
            CH_LN, CH_LQ, CH_UN, CH_UQ:
                predict_segment(pen[0], pen[1], dec_args[0], dec_args[1]);
            CH_LL, CH_LV:
                predict_segment(dec_args[0], dec_args[1], dec_args[2], dec_args[3]);
            CH_UL, CH_UV:
                predict_segment(dec_args[0], dec_args[1], dec_args[3], dec_args[4]);
            CH_LP, CH_LX, CH_UP, CH_UX:
                predict_segment(dec_args[0], dec_args[1], dec_args[0], dec_args[1]);
            default: ;
        endcase
    endtask

    function automatic logic [7:0] table_entry(input logic [7:0] b);
        return (b >= CH_A && b <= CH_LZ) ? CMD_TABLE[b - CH_A] : 8'h00;
    endfunction

    // advance the mirrored decoder by one transferred byte
    task automatic decode_byte(input logic [7:0] b);
        logic [7:0] ent;
        logic [3:0] kind;
        bit         done;
        if (dec_phase == PH_TEXT) begin
            if (b == CH_NL) begin
                dec_phase = PH_CMD;
            end
        end else if (dec_phase == PH_CMD) begin
            ent = table_entry(b);
            kind = ent[7:4];
            if (kind == K_BAD) begin
                events_due.push_back('{EV_BAD, 0, 0, 0, 0, b});
            end else if (kind == K_NONE) begin
                events_due.push_back('{(b == CH_F) ? EV_FLUSH : EV_ERASE, 0, 0, 0, 0, 8'd0});
            end else if (kind == K_TEXT) begin
                dec_phase = PH_TEXT;
            end else begin
                dec_cmd = b;
                dec_arg = 0;
                dec_byte = 0;
                dec_asm = 0;
                dec_phase = PH_ARGS;
            end
        end else begin
            ent = table_entry(dec_cmd);
            kind = ent[7:4];
            done = 1'b1;
            if (kind == K_SHORT) begin
                dec_asm |= 64'(b) << (8 * (dec_byte & 1));
                done = dec_byte >= 1;
                if (done) begin
                    dec_args[dec_arg % 6] = longint'(signed'(dec_asm[15:0])) <<< FRAC_BITS;
                end
            end else if (kind == K_IEEE) begin
                dec_asm = {dec_asm[55:0], b};
                done = dec_byte >= 7;
                if (done) begin
                    dec_args[dec_arg % 6] = fixed_of_double(dec_asm);
                end
            end
            if (!done) begin
                dec_byte = (dec_byte + 1) & 7;
            end else begin
                dec_byte = 0;
                dec_asm = 0;
                dec_arg = (dec_arg + 1) & 7;
                if (dec_arg >= ent[3:0]) begin
                    dec_phase = PH_CMD;
                    dec_arg = 0;
                    run_command();
                end
            end
        end
    endtask

    // ---------------------------------------------------------------- stimulus
    logic [7:0] letters [$];
    int         bytes_made = 0;

    task automatic put_byte(input logic [7:0] b);
        stream_bytes.push_back(b);
        bytes_made++;
    endtask

    task automatic put_short(input logic [15:0] v);
        put_byte(v[7:0]);
        put_byte(v[15:8]);
    endtask

    task automatic put_double(input logic [63:0] v);
        for (int i = 7; i >= 0; i--) begin
            put_byte(v[8*i +: 8]);
        end
    endtask

    function automatic logic [15:0] any_short();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
            return 16'($urandom_range(0, 2000) - 1000);
        end
        if (pick == 7) begin
            case ($urandom_range(0, 3))
                0: return 16'h7FFF;
                1: return 16'h8000;
                2: return 16'hFFFF;
                default: return 16'h0000;
            endcase
        end
        return 16'($urandom);
    endfunction

    function automatic logic [63:0] any_double();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            return $realtobits(real'(int'($urandom_range(0, 4000)) - 2000) / 8.0);
        end
        if (pick < 8) begin
            case ($urandom_range(0, 6))
                0: return 64'h7FF8_0000_0000_0000;   // quiet nan
                1: return 64'h7FF0_0000_0000_0000;   // +inf
                2: return 64'hFFF0_0000_0000_0000;   // -inf
                3: return 64'h0000_0000_0000_0001;   // smallest denormal
                4: return 64'hC340_0000_0000_0000;   // far out of range
                5: return 64'h8000_0000_0000_0000;   // negative zero
                default: return $realtobits(1.0e-6);
            endcase
        end
        return {$urandom, $urandom};
    endfunction

    // a command letter with arguments of the kind it takes
    task automatic put_command(input logic [7:0] c);
        logic [7:0] ent;
        ent = table_entry(c);
        put_byte(c);
        case (ent[7:4])
            K_SHORT: repeat (ent[3:0]) put_short(any_short());
            K_IEEE:  repeat (ent[3:0]) put_double(any_double());
            K_CHAR:  repeat (ent[3:0]) put_byte(8'($urandom));
            K_TEXT: begin
                repeat ($urandom_range(0, 6)) put_byte(8'($urandom_range(8'h20, 8'h7E)));
                put_byte(CH_NL);
            end
            default: ;
        endcase
    endtask

    task automatic put_space(input bit degenerate);
        logic [15:0] x0, y0;
        x0 = 16'($urandom_range(0, 400) - 200);
        y0 = 16'($urandom_range(0, 400) - 200);
        put_byte(CH_LS);
        put_short(x0);
        put_short(y0);
        put_short((degenerate && $urandom_range(0, 1)) ? x0
                  : 16'(x0 + (($urandom_range(0, 1)) ? 1 : -1) * $urandom_range(1, 900)));
        put_short((degenerate) ? y0
                  : 16'(y0 + (($urandom_range(0, 1)) ? 1 : -1) * $urandom_range(1, 900)));
    endtask

    task automatic put_random_chunk();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            put_space($urandom_range(0, 9) == 0);
        end else if (pick < 50) begin
            case ($urandom_range(0, 4))
                0: put_command(CH_LL);
                1: put_command(CH_LN);
                2: put_command(CH_LP);
                3: put_command(CH_LM);
                default: put_command(CH_UL);
            endcase
        end else if (pick < 85) begin
            put_command(letters[$urandom_range(0, letters.size() - 1)]);
        end else begin
            put_byte(8'($urandom));                // noise
        end
    endtask

    // ---------------------------------------------------------------- drivers
    int burst_left = 0;
    int gap_left = 0;

    // sender: bursts of offered transfers separated by random gaps
    always @(negedge i_clk) begin
        if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            push <= 1'b0;
        end else if (i_rst_n && stream_bytes.size() != 0) begin
            push <= 1'b1;
            i_stream_byte <= stream_bytes[0];
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 40);
                gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            push <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (push && !full) begin
            void'(stream_bytes.pop_front());
            decode_byte(i_stream_byte);
        end
    end

    // receiver: alternates between always-ready and stalling stretches,
    // plus one long hold-off on request
    int hold_asked = 0;
    int hold_done = 0;
    int hold_left = 0;
    int mode_left = 0;
    bit stall_mode = 1'b0;

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            pop <= 1'b0;
        end else if (hold_done != hold_asked) begin
            hold_done <= hold_asked;
            hold_left <= 600;
            pop <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                mode_left <= $urandom_range(30, 200);
                stall_mode <= ~stall_mode;
            end else begin
                mode_left <= mode_left - 1;
            end
            pop <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_plot_event want;
        if (pop && !empty) begin
            if (events_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected event kind %0d at %0t", o_event_kind, $realtime);
                end
            end else begin
                want = events_due.pop_front();
                if (o_event_kind !== want.kind || o_start_x !== want.sx
                        || o_start_y !== want.sy || o_end_x !== want.ex
                        || o_end_y !== want.ey || o_bad_byte !== want.bad) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("event at %0t: expected %0d (%0d,%0d)-(%0d,%0d) bad %h",
                                 $realtime, want.kind, want.sx, want.sy, want.ex, want.ey,
                                 want.bad);
                        $display("                got %0d (%0d,%0d)-(%0d,%0d) bad %h",
                                 o_event_kind, o_start_x, o_start_y, o_end_x, o_end_y,
                                 o_bad_byte);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------- registers
    task automatic reg_write(input int idx, input logic [12:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 3'(4 * idx);
        pwdata <= {19'd0, val};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (idx == 0) begin
            win_w = val;
        end else begin
            win_h = val;
        end
        @(negedge i_clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== {19'd0, val}) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("register %0d read %h, expected %h", idx, prdata, val);
            end
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // settle: all bytes transferred, all events back, divider drained
    task automatic wait_idle();
        while (stream_bytes.size() != 0 || events_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (300) @(posedge i_clk);
    endtask

    initial begin
        #40_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        logic [12:0] widths [4]  = '{13'd640, 13'd1, 13'd4096, 13'd8191};
        logic [12:0] heights [4] = '{13'd480, 13'd4096, 13'd1, 13'd0};
        for (int i = 0; i < 6; i++) dec_args[i] = 0;
        for (int i = 0; i < 4; i++) win[i] = 0;
        pen[0] = 0;
        pen[1] = 0;
        for (int c = CH_A; c <= CH_LZ; c++) begin
            if (table_entry(8'(c)) != 8'h00) begin
                letters.push_back(8'(c));
            end
        end
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: bad bytes at and around the letter range, events, skips
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(CH_A - 8'd1);
        put_byte(CH_LZ + 8'd1);
        put_byte(CH_A);                         // letter with no meaning
        put_byte(CH_LZ);
        put_command(8'h65);                     // erase
        put_byte(CH_F);                         // flush
        put_command(8'h74);                     // label text
        put_command(8'h66);                     // line mode text
        put_command(8'h43);                     // color bytes
        put_command(CH_LN);                     // draw with the zero window
        put_space(1'b1);                        // zero extent window
        put_command(CH_LL);
        put_byte(CH_LS);
        put_short(16'h8000); put_short(16'h8000); put_short(16'h7FFF); put_short(16'h7FFF);
        put_byte(CH_LL);
        put_short(16'h8000); put_short(16'h7FFF); put_short(16'h7FFF); put_short(16'h8000);
        put_space(1'b0);
        put_command(CH_LP);
        put_command(CH_LM);
        put_command(CH_LN);
        put_byte(CH_LW);                        // double window, then specials
        put_double($realtobits(-10.0)); put_double($realtobits(-10.0));
        put_double($realtobits(10.0));  put_double($realtobits(10.0));
        put_byte(CH_LV);
        put_double(64'h7FF8_0000_0000_0000); put_double(64'h7FF0_0000_0000_0000);
        put_double(64'hFFF0_0000_0000_0000); put_double(64'h0000_0000_0000_0001);
        put_command(CH_UL);
        put_command(CH_UV);
        put_command(CH_UX);
        put_command(CH_LQ);
        wait_idle();

        // random phases, one register setting each
        for (int ph = 0; ph < 4; ph++) begin
            reg_write(0, widths[ph]);
            reg_write(1, heights[ph]);
            while (bytes_made < 450 * (ph + 1) + 150) begin
                put_random_chunk();
            end
            if (ph == 1) begin
                // long receiver hold-off while the sender keeps offering
                @(posedge i_clk);
                hold_asked = hold_asked + 1;
            end
            wait_idle();
        end

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/psvd_pkg.sv
src/psvd_front.sv
src/psvd_jobq.sv
src/psvd_back.sv
src/plot_stream_vector_decoder.sv
sim/plot_stream_vector_decoder_test.sv
